// ===== rtl/core/gm_pkg.sv =====
// Shared constants, function codes and control types for the glob matcher.
package gm_pkg;

    localparam int DEF_PATTERN_DEPTH = 16;
    localparam int DEF_SUBJECT_DEPTH = 16;

    localparam int CHAR_W = 8;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FN_PAT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SUB = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RUN = 2'd2;

    localparam logic [CHAR_W-1:0] STAR_CODE  = 8'h2A;
    localparam logic [CHAR_W-1:0] QMARK_CODE = 8'h3F;

    typedef struct packed {
        logic              pat_we;
        logic              sub_we;
        logic              start;
        logic [CHAR_W-1:0] data;
    } gm_cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
    } gm_sts_t;

endpackage

// ===== rtl/core/gm_if.sv =====
// Valid/ready channel interfaces for the glob matcher input and result words.
interface gm_in_if;
    import gm_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output func, output char_code, input ready);
    modport sink (input valid, input func, input char_code, output ready);
endinterface

interface gm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic overflowed;

    modport source (output valid, output matched, output overflowed, input ready);
    modport sink (input valid, input matched, input overflowed, output ready);
endinterface

// ===== rtl/core/gm_walker.sv =====
// Pattern and subject stores with the sequencer that walks them for one match run.
module gm_walker #(
    parameter int PATTERN_DEPTH = gm_pkg::DEF_PATTERN_DEPTH,
    parameter int SUBJECT_DEPTH = gm_pkg::DEF_SUBJECT_DEPTH,
    localparam int PLW = $clog2(PATTERN_DEPTH + 1),
    localparam int SLW = $clog2(SUBJECT_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gm_pkg::gm_cmd_t  cmd,
    input  logic [PLW-1:0]   pat_len,
    input  logic [SLW-1:0]   sub_len,
    output gm_pkg::gm_sts_t  sts
);
    import gm_pkg::*;

    localparam int PIW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int SIW = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;

    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_FETCH = 2'd1;
    localparam logic [1:0] W_EVAL  = 2'd2;

    logic [CHAR_W-1:0] pat_mem [PATTERN_DEPTH];
    logic [CHAR_W-1:0] sub_mem [SUBJECT_DEPTH];
    logic [CHAR_W-1:0] pat_rd_reg;
    logic [CHAR_W-1:0] sub_rd_reg;

    logic [1:0]     state_reg, state_next;
    logic [PLW-1:0] p_reg, p_next;
    logic [SLW-1:0] s_reg, s_next;
    logic [PLW-1:0] rp_reg, rp_next;
    logic [SLW-1:0] rs_reg, rs_next;
    logic           star_reg, star_next;
    logic           done_reg, done_next;
    logic           hit_reg, hit_next;

    logic [PLW-1:0] p_inc;
    logic [SLW-1:0] s_inc;
    logic [SLW-1:0] rs_inc;
    logic           p_lt;
    logic           s_lt;
    logic           is_star;
    logic           lit_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.pat_we)
        begin
            pat_mem[pat_len[PIW-1:0]] <= cmd.data;
        end
        if (cmd.sub_we)
        begin
            sub_mem[sub_len[SIW-1:0]] <= cmd.data;
        end
        pat_rd_reg <= pat_mem[p_reg[PIW-1:0]];
        sub_rd_reg <= sub_mem[s_reg[SIW-1:0]];
    end

    assign p_inc   = p_reg + PLW'(1);
    assign s_inc   = s_reg + SLW'(1);
    assign rs_inc  = rs_reg + SLW'(1);
    assign p_lt    = p_reg < pat_len;
    assign s_lt    = s_reg < sub_len;
    assign is_star = pat_rd_reg == STAR_CODE;
    assign lit_ok  = (pat_rd_reg == sub_rd_reg) || (pat_rd_reg == QMARK_CODE);

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        s_next     = s_reg;
        rp_next    = rp_reg;
        rs_next    = rs_reg;
        star_next  = star_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (cmd.start)
                begin
                    p_next     = '0;
                    s_next     = '0;
                    rp_next    = '0;
                    rs_next    = '0;
                    star_next  = 1'b0;
                    state_next = W_FETCH;
                end
            end
            W_FETCH:
            begin
                if (!s_lt && !p_lt)
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b1;
                    state_next = W_IDLE;
                end
                else
                begin
                    state_next = W_EVAL;
                end
            end
            W_EVAL:
            begin
                state_next = W_FETCH;
                if (s_lt)
                begin
                    if (p_lt && is_star)
                    begin
                        p_next = p_inc;
                        if (p_inc >= pat_len)
                        begin
                            done_next  = 1'b1;
                            hit_next   = 1'b1;
                            state_next = W_IDLE;
                        end
                        else
                        begin
                            star_next = 1'b1;
                            rp_next   = p_inc;
                            rs_next   = s_inc;
                        end
                    end
                    else if (p_lt && lit_ok)
                    begin
                        p_next = p_inc;
                        s_next = s_inc;
                    end
                    else if (!star_reg)
                    begin
                        done_next  = 1'b1;
                        hit_next   = 1'b0;
                        state_next = W_IDLE;
                    end
                    else
                    begin
                        p_next  = rp_reg;
                        s_next  = rs_reg;
                        rs_next = rs_inc;
                    end
                end
                else if (is_star)
                begin
                    p_next = p_inc;
                end
                else
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        s_reg    <= s_next;
        rp_reg   <= rp_next;
        rs_reg   <= rs_next;
        star_reg <= star_next;
        hit_reg  <= hit_next;
    end

    assign sts = '{done: done_reg, hit: hit_reg};

endmodule

// ===== rtl/core/wildcard_glob_matcher_unit.sv =====
// Glob matcher top level: command handshake, store lengths, overflow flag and result register.
//
// Each input word either appends one byte to the pattern or subject store, or runs a match.
// Appends and ignored codes leave the block idle, so the input stays ready for the next word.
// A run walks both stores with the single-star backtracking scan; each walk step passes
// through a fetch state that issues one registered read to each store and an evaluate state
// that checks the fetched pair. The step count is at most roughly (PATTERN_DEPTH + 1) *
// (SUBJECT_DEPTH + 1); a run after an overflow skips the walk and answers with no match.
// The input is not ready during a run. The result word sits in an output register, so
// appends for the next run are taken while it waits to be read. Each run resets both store
// lengths and the overflow flag once its result is registered.
module wildcard_glob_matcher_unit #(
    parameter int PATTERN_DEPTH = gm_pkg::DEF_PATTERN_DEPTH,
    parameter int SUBJECT_DEPTH = gm_pkg::DEF_SUBJECT_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    gm_in_if.sink    in_ch,
    gm_out_if.source out_ch
);
    import gm_pkg::*;

    localparam int PLW = $clog2(PATTERN_DEPTH + 1);
    localparam int SLW = $clog2(SUBJECT_DEPTH + 1);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_WALK = 2'd1;
    localparam logic [1:0] T_HOLD = 2'd2;

    logic [1:0]     state_reg, state_next;
    logic [PLW-1:0] pat_len_reg, pat_len_next;
    logic [SLW-1:0] sub_len_reg, sub_len_next;
    logic           ovf_reg, ovf_next;
    logic           hit_reg, hit_next;
    logic           out_valid_reg, out_valid_next;
    logic           matched_reg, matched_next;
    logic           overflowed_reg, overflowed_next;

    logic    accept;
    logic    pat_room;
    logic    sub_room;
    gm_cmd_t cmd;
    gm_sts_t sts;

    assign in_ch.ready = state_reg == T_IDLE;
    assign accept      = in_ch.valid && in_ch.ready;
    assign pat_room    = pat_len_reg < PLW'(PATTERN_DEPTH);
    assign sub_room    = sub_len_reg < SLW'(SUBJECT_DEPTH);

    assign cmd.pat_we = accept && (in_ch.func == FN_PAT) && pat_room;
    assign cmd.sub_we = accept && (in_ch.func == FN_SUB) && sub_room;
    assign cmd.start  = accept && (in_ch.func == FN_RUN) && !ovf_reg;
    assign cmd.data   = in_ch.char_code;

    gm_walker #(
        .PATTERN_DEPTH (PATTERN_DEPTH),
        .SUBJECT_DEPTH (SUBJECT_DEPTH)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .pat_len (pat_len_reg),
        .sub_len (sub_len_reg),
        .sts     (sts)
    );

    always_comb
    begin
        state_next      = state_reg;
        pat_len_next    = pat_len_reg;
        sub_len_next    = sub_len_reg;
        ovf_next        = ovf_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        matched_next    = matched_reg;
        overflowed_next = overflowed_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_ch.func)
                        FN_PAT:
                        begin
                            if (pat_room)
                            begin
                                pat_len_next = pat_len_reg + PLW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FN_SUB:
                        begin
                            if (sub_room)
                            begin
                                sub_len_next = sub_len_reg + SLW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FN_RUN:
                        begin
                            if (ovf_reg)
                            begin
                                hit_next   = 1'b0;
                                state_next = T_HOLD;
                            end
                            else
                            begin
                                state_next = T_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = T_IDLE;
                        end
                    endcase
                end
            end
            T_WALK:
            begin
                if (sts.done)
                begin
                    hit_next   = sts.hit;
                    state_next = T_HOLD;
                end
            end
            T_HOLD:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    matched_next    = hit_reg;
                    overflowed_next = ovf_reg;
                    pat_len_next    = '0;
                    sub_len_next    = '0;
                    ovf_next        = 1'b0;
                    state_next      = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pat_len_reg   <= '0;
            sub_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pat_len_reg   <= pat_len_next;
            sub_len_reg   <= sub_len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg        <= hit_next;
        matched_reg    <= matched_next;
        overflowed_reg <= overflowed_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.matched    = matched_reg;
    assign out_ch.overflowed = overflowed_reg;

endmodule

// ===== rtl/core/gm_checker.sv =====
// Port-level assertions for the glob matcher and the bind that attaches them.
module gm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [gm_pkg::FUNC_W-1:0] in_func,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      out_matched,
    input logic                      out_overflowed
);
    import gm_pkg::*;

    // A waiting result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_matched)
                                       && $stable(out_overflowed)))
    else $error("result word changed or dropped while stalled");

    // A run that saw an overflow never reports a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_overflowed) |-> !out_matched)
    else $error("overflowed run reported a match");

    // An accepted run blocks the input on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_func == FN_RUN) |=> !in_ready)
    else $error("input still ready after a run was accepted");

    // The input reopens only together with a registered result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
    else $error("input reopened without a result word");

endmodule

bind wildcard_glob_matcher_unit gm_checker u_gm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_func        (in_ch.func),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_matched    (out_ch.matched),
    .out_overflowed (out_ch.overflowed)
);
